/* src/dcca_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package dcca_pkg;
    localparam int PROCESS_SLOTS_DEF = 16;
    localparam int NUM_DEVICES_DEF   = 4;
    localparam int NUM_CTRLS_DEF     = 3;
    localparam int NUM_CHANS_DEF     = 2;
    localparam int QUEUE_DEPTH_DEF   = 16;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ACTIVE  = 3'd1;
    localparam logic [2:0] ST_UNKNOWN = 3'd2;
    localparam logic [2:0] ST_NOCHAN  = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    localparam logic [1:0] STG_WAIT_DEV  = 2'd0;
    localparam logic [1:0] STG_WAIT_CTRL = 2'd1;
    localparam logic [1:0] STG_WAIT_CHAN = 2'd2;
    localparam logic [1:0] STG_HOLD_CHAN = 2'd3;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    localparam logic CFG_DEV_CTRL  = 1'b0;
    localparam logic CFG_CTRL_CHAN = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_DEV,
        S_DEV_POP,
        S_RD_CTRL,
        S_CTRL_POP,
        S_RD_CHAN,
        S_CHAN_POP,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

/* src/dcca_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module dcca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* src/device_controller_channel_allocator_top.sv */
`timescale 1ns / 1ps
// Device/controller/channel allocator with per-level FIFO wait queues.
// Request or failed release: S_RD_DEV then S_DONE. Good release: S_RD_DEV,
// then queue-memory read and pop per device, controller, channel; S_DONE.
// Throughput: one transaction at a time; busy stays high through the strobe cycle.
// Reset (synchronous, active low) frees all owners and empties all queues.
// The receiver cannot stall: o_done is a one-cycle strobe.
`default_nettype none
module device_controller_channel_allocator_top
    import dcca_pkg::*;
#(
    parameter int PROCESS_SLOTS = PROCESS_SLOTS_DEF,
    parameter int NUM_DEVICES   = NUM_DEVICES_DEF,
    parameter int NUM_CTRLS     = NUM_CTRLS_DEF,
    parameter int NUM_CHANS     = NUM_CHANS_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_req_type,
    input  wire logic [3:0] i_process_id,
    input  wire logic [1:0] i_device_id,
    output logic            o_done,
    output logic [2:0]      o_status,
    output logic [1:0]      o_stage
);
    localparam int PW = (PROCESS_SLOTS > 16) ? $clog2(PROCESS_SLOTS) : 4;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int DW = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
    localparam int KW = (NUM_CTRLS > 1) ? $clog2(NUM_CTRLS) : 1;
    localparam int HW = (NUM_CHANS > 1) ? $clog2(NUM_CHANS) : 1;
    localparam int DQ = NUM_DEVICES * QUEUE_DEPTH;
    localparam int KQ = NUM_CTRLS * QUEUE_DEPTH;
    localparam int HQ = NUM_CHANS * QUEUE_DEPTH;
    localparam int PSW = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;

    // configuration
    logic [7:0] r_dev_ctrl;
    logic [2:0] r_ctrl_chan;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_ctrl  <= 8'd144;
            r_ctrl_chan <= 3'd6;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_DEV_CTRL) r_dev_ctrl <= i_cfg_data;
            else r_ctrl_chan <= i_cfg_data[2:0];
        end
    end

    // owners and queue pointers (small, in flops)
    logic [NUM_DEVICES-1:0] r_dbusy;
    logic [NUM_CTRLS-1:0]   r_kbusy;
    logic [NUM_CHANS-1:0]   r_hbusy;
    logic [PW-1:0] r_dwho [NUM_DEVICES];
    logic [PW-1:0] r_kwho [NUM_CTRLS];
    logic [PW-1:0] r_hwho [NUM_CHANS];
    logic [QW-1:0] r_dhead [NUM_DEVICES];
    logic [QW-1:0] r_khead [NUM_CTRLS];
    logic [QW-1:0] r_hhead [NUM_CHANS];
    logic [CW-1:0] r_dcnt [NUM_DEVICES];
    logic [CW-1:0] r_kcnt [NUM_CTRLS];
    logic [CW-1:0] r_hcnt [NUM_CHANS];
    logic [PROCESS_SLOTS-1:0] r_active;

    // transaction registers
    t_state r_state, n_state;
    logic          r_type;
    logic [PW-1:0] r_pid;
    logic [DW-1:0] r_d;
    logic [KW-1:0] r_k;
    logic [HW-1:0] r_h;
    logic [2:0]    r_status;
    logic [1:0]    r_stage;

    function automatic logic [KW-1:0] ctrl_of(input logic [7:0] m, input logic [DW-1:0] d);
        logic [1:0] c;
        c = 2'd0;
        if ({{(32-DW){1'b0}}, d} < 32'd4) c = m[2*d +: 2];
        if ({30'd0, c} >= NUM_CTRLS) return KW'(NUM_CTRLS - 1);
        return KW'(c);
    endfunction

    function automatic logic [HW-1:0] chan_of(input logic [2:0] m, input logic [KW-1:0] k);
        logic h;
        h = 1'b0;
        if ({{(32-KW){1'b0}}, k} < 32'd3) h = m[k];
        if ({31'd0, h} >= NUM_CHANS) return HW'(NUM_CHANS - 1);
        return HW'(h);
    endfunction

    // process-to-device memory
    logic          pd_we;
    logic [PSW-1:0] pd_waddr, pd_raddr;
    logic [1:0]    pd_wdata, pd_rdata;
    dcca_ram #(.WIDTH(2), .DEPTH(PROCESS_SLOTS)) u_pd (
        .i_clk, .i_we(pd_we), .i_waddr(pd_waddr), .i_wdata(pd_wdata),
        .i_raddr(pd_raddr), .o_rdata(pd_rdata));

    // queue memories
    logic dq_we, kq_we, hq_we;
    logic [$clog2(DQ)-1:0] dq_wa, dq_ra;
    logic [$clog2(KQ)-1:0] kq_wa, kq_ra;
    logic [$clog2(HQ)-1:0] hq_wa, hq_ra;
    logic [PW-1:0] dq_wd, kq_wd, hq_wd, dq_rd, kq_rd, hq_rd;
    dcca_ram #(.WIDTH(PW), .DEPTH(DQ)) u_dq (
        .i_clk, .i_we(dq_we), .i_waddr(dq_wa), .i_wdata(dq_wd),
        .i_raddr(dq_ra), .o_rdata(dq_rd));
    dcca_ram #(.WIDTH(PW), .DEPTH(KQ)) u_kq (
        .i_clk, .i_we(kq_we), .i_waddr(kq_wa), .i_wdata(kq_wd),
        .i_raddr(kq_ra), .o_rdata(kq_rd));
    dcca_ram #(.WIDTH(PW), .DEPTH(HQ)) u_hq (
        .i_clk, .i_we(hq_we), .i_waddr(hq_wa), .i_wdata(hq_wd),
        .i_raddr(hq_ra), .o_rdata(hq_rd));

    logic [DW-1:0] in_d;
    logic [KW-1:0] in_k;
    logic [HW-1:0] in_h;
    logic [DW-1:0] rel_d;
    logic [KW-1:0] rel_k;
    logic [HW-1:0] rel_h;
    logic          holds;
    logic          accept;

    assign accept = start && !busy;
    assign in_d   = DW'(i_device_id);
    assign in_k   = ctrl_of(r_dev_ctrl, in_d);
    assign in_h   = chan_of(r_ctrl_chan, in_k);
    assign rel_d  = ({30'd0, pd_rdata} >= NUM_DEVICES) ? DW'(NUM_DEVICES - 1) : DW'(pd_rdata);
    assign rel_k  = ctrl_of(r_dev_ctrl, rel_d);
    assign rel_h  = chan_of(r_ctrl_chan, rel_k);

    always_comb begin
        holds = 1'b0;
        for (int i = 0; i < NUM_CHANS; i++)
            if (r_hbusy[i] && r_hwho[i] == r_pid) holds = 1'b1;
    end

    assign pd_raddr = PSW'(i_process_id);
    assign pd_we    = (r_state == S_RD_DEV) && r_type == REQ_ALLOC && r_status == ST_OK;
    assign pd_waddr = PSW'(r_pid);
    assign pd_wdata = 2'(r_d);

    // queue read addresses: head of the level being freed
    assign dq_ra = $clog2(DQ)'(r_d) * $clog2(DQ)'(QUEUE_DEPTH) + $clog2(DQ)'(r_dhead[r_d]);
    assign kq_ra = $clog2(KQ)'(r_k) * $clog2(KQ)'(QUEUE_DEPTH) + $clog2(KQ)'(r_khead[r_k]);
    assign hq_ra = $clog2(HQ)'(r_h) * $clog2(HQ)'(QUEUE_DEPTH) + $clog2(HQ)'(r_hhead[r_h]);

    // tail positions
    function automatic logic [QW-1:0] tail(input logic [QW-1:0] hd, input logic [CW-1:0] c);
        logic [QW+CW:0] s;
        s = (QW+CW+1)'(hd) + (QW+CW+1)'(c);
        if (s >= (QW+CW+1)'(QUEUE_DEPTH)) s = s - (QW+CW+1)'(QUEUE_DEPTH);
        return QW'(s);
    endfunction

    function automatic logic [QW-1:0] inc(input logic [QW-1:0] hd);
        if ({{(32-QW){1'b0}}, hd} == QUEUE_DEPTH - 1) return '0;
        return hd + QW'(1);
    endfunction

    // next-state logic
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (accept) n_state = S_RD_DEV;
            S_RD_DEV:   n_state = (r_type == REQ_RELEASE && r_status == ST_OK && holds)
                                  ? S_DEV_POP : S_DONE;
            S_DEV_POP:  n_state = S_RD_CTRL;
            S_RD_CTRL:  n_state = S_CTRL_POP;
            S_CTRL_POP: n_state = S_RD_CHAN;
            S_RD_CHAN:  n_state = S_CHAN_POP;
            S_CHAN_POP: n_state = S_DONE;
            S_DONE:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        busy     = (r_state != S_IDLE);
        o_done   = (r_state == S_DONE);
        o_status = r_status;
        o_stage  = r_stage;
    end

    // queue writes: request enqueue happens in S_RD_DEV, release pushes later
    always_comb begin
        dq_we = 1'b0; kq_we = 1'b0; hq_we = 1'b0;
        dq_wa = '0; kq_wa = '0; hq_wa = '0;
        dq_wd = r_pid; kq_wd = r_pid; hq_wd = r_pid;
        if (r_state == S_RD_DEV && r_type == REQ_ALLOC && r_status == ST_OK) begin
            dq_wa = $clog2(DQ)'(r_d) * $clog2(DQ)'(QUEUE_DEPTH)
                  + $clog2(DQ)'(tail(r_dhead[r_d], r_dcnt[r_d]));
            kq_wa = $clog2(KQ)'(r_k) * $clog2(KQ)'(QUEUE_DEPTH)
                  + $clog2(KQ)'(tail(r_khead[r_k], r_kcnt[r_k]));
            hq_wa = $clog2(HQ)'(r_h) * $clog2(HQ)'(QUEUE_DEPTH)
                  + $clog2(HQ)'(tail(r_hhead[r_h], r_hcnt[r_h]));
            // a full queue takes nothing
            if (r_dbusy[r_d]) dq_we = (r_dcnt[r_d] < CW'(QUEUE_DEPTH));
            else if (r_kbusy[r_k]) kq_we = (r_kcnt[r_k] < CW'(QUEUE_DEPTH));
            else if (r_hbusy[r_h]) hq_we = (r_hcnt[r_h] < CW'(QUEUE_DEPTH));
        end
        if (r_state == S_CTRL_POP && r_kcnt[r_k] != '0 && r_dbusy[r_d]) begin
            kq_we = 1'b1;
            kq_wd = r_dwho[r_d];
            kq_wa = $clog2(KQ)'(r_k) * $clog2(KQ)'(QUEUE_DEPTH)
                  + $clog2(KQ)'(tail(inc(r_khead[r_k]), r_kcnt[r_k] - CW'(1)));
        end
        if (r_state == S_CHAN_POP && r_hcnt[r_h] != '0 && r_kbusy[r_k]) begin
            hq_we = 1'b1;
            hq_wd = r_kwho[r_k];
            hq_wa = $clog2(HQ)'(r_h) * $clog2(HQ)'(QUEUE_DEPTH)
                  + $clog2(HQ)'(tail(inc(r_hhead[r_h]), r_hcnt[r_h] - CW'(1)));
        end
    end

    // state and owner updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_dbusy  <= '0;
            r_kbusy  <= '0;
            r_hbusy  <= '0;
            r_active <= '0;
            for (int i = 0; i < NUM_DEVICES; i++) begin
                r_dhead[i] <= '0; r_dcnt[i] <= '0;
            end
            for (int i = 0; i < NUM_CTRLS; i++) begin
                r_khead[i] <= '0; r_kcnt[i] <= '0;
            end
            for (int i = 0; i < NUM_CHANS; i++) begin
                r_hhead[i] <= '0; r_hcnt[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    // check and latch the transaction
                    if (accept) begin
                        r_type   <= i_req_type;
                        r_pid    <= PW'(i_process_id);
                        r_d      <= in_d;
                        r_k      <= in_k;
                        r_h      <= in_h;
                        r_stage  <= STG_WAIT_DEV;
                        r_status <= ST_OK;
                        if ({{(32-4){1'b0}}, i_process_id} >= PROCESS_SLOTS)
                            r_status <= ST_UNKNOWN;
                        else if (i_req_type == REQ_ALLOC) begin
                            if (r_active[PSW'(i_process_id)]) r_status <= ST_ACTIVE;
                            else if ({{(32-2){1'b0}}, i_device_id} >= NUM_DEVICES)
                                r_status <= ST_UNKNOWN;
                        end else if (!r_active[PSW'(i_process_id)])
                            r_status <= ST_UNKNOWN;
                    end
                end
                S_RD_DEV: begin
                    if (r_type == REQ_ALLOC && r_status == ST_OK) begin
                        // place the request at the first busy level
                        if (r_dbusy[r_d]) begin
                            if (r_dcnt[r_d] >= CW'(QUEUE_DEPTH)) r_status <= ST_FULL;
                            else begin
                                r_dcnt[r_d] <= r_dcnt[r_d] + CW'(1);
                                r_active[PSW'(r_pid)] <= 1'b1;
                            end
                        end else if (r_kbusy[r_k]) begin
                            if (r_kcnt[r_k] >= CW'(QUEUE_DEPTH)) r_status <= ST_FULL;
                            else begin
                                r_kcnt[r_k] <= r_kcnt[r_k] + CW'(1);
                                r_active[PSW'(r_pid)] <= 1'b1;
                                r_dbusy[r_d] <= 1'b1; r_dwho[r_d] <= r_pid;
                                r_stage <= STG_WAIT_CTRL;
                            end
                        end else if (r_hbusy[r_h]) begin
                            if (r_hcnt[r_h] >= CW'(QUEUE_DEPTH)) r_status <= ST_FULL;
                            else begin
                                r_hcnt[r_h] <= r_hcnt[r_h] + CW'(1);
                                r_active[PSW'(r_pid)] <= 1'b1;
                                r_dbusy[r_d] <= 1'b1; r_dwho[r_d] <= r_pid;
                                r_kbusy[r_k] <= 1'b1; r_kwho[r_k] <= r_pid;
                                r_stage <= STG_WAIT_CHAN;
                            end
                        end else begin
                            r_active[PSW'(r_pid)] <= 1'b1;
                            r_dbusy[r_d] <= 1'b1; r_dwho[r_d] <= r_pid;
                            r_kbusy[r_k] <= 1'b1; r_kwho[r_k] <= r_pid;
                            r_hbusy[r_h] <= 1'b1; r_hwho[r_h] <= r_pid;
                            r_stage <= STG_HOLD_CHAN;
                        end
                    end else if (r_type == REQ_RELEASE && r_status == ST_OK) begin
                        if (!holds) r_status <= ST_NOCHAN;
                        else begin
                            // free the path named by the current maps
                            r_d <= rel_d; r_k <= rel_k; r_h <= rel_h;
                            r_active[PSW'(r_pid)] <= 1'b0;
                            r_dbusy[rel_d] <= 1'b0;
                            r_kbusy[rel_k] <= 1'b0;
                            r_hbusy[rel_h] <= 1'b0;
                        end
                    end
                end
                S_DEV_POP: ;  // device queue head read in flight
                S_RD_CTRL: begin
                    // hand the device to its queue head
                    if (r_dcnt[r_d] != '0) begin
                        r_dbusy[r_d] <= 1'b1; r_dwho[r_d] <= dq_rd;
                        r_dhead[r_d] <= inc(r_dhead[r_d]);
                        r_dcnt[r_d]  <= r_dcnt[r_d] - CW'(1);
                    end
                end
                S_CTRL_POP: begin
                    // hand the controller on; new device holder moves down
                    if (r_kcnt[r_k] != '0) begin
                        r_kbusy[r_k] <= 1'b1; r_kwho[r_k] <= kq_rd;
                        r_khead[r_k] <= inc(r_khead[r_k]);
                        if (!r_dbusy[r_d]) r_kcnt[r_k] <= r_kcnt[r_k] - CW'(1);
                    end else if (r_dbusy[r_d]) begin
                        r_kbusy[r_k] <= 1'b1; r_kwho[r_k] <= r_dwho[r_d];
                    end
                end
                S_RD_CHAN: ;
                S_CHAN_POP: begin
                    if (r_hcnt[r_h] != '0) begin
                        r_hbusy[r_h] <= 1'b1; r_hwho[r_h] <= hq_rd;
                        r_hhead[r_h] <= inc(r_hhead[r_h]);
                        if (!r_kbusy[r_k]) r_hcnt[r_h] <= r_hcnt[r_h] - CW'(1);
                    end else if (r_kbusy[r_k]) begin
                        r_hbusy[r_h] <= 1'b1; r_hwho[r_h] <= r_kwho[r_k];
                    end
                end
                S_DONE: ;
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire
